/* rtl/core/upd_pkg.sv */
`default_nettype none
package upd_pkg;

   localparam int unsigned QDEPTH   = 4;
   localparam int unsigned MAX_EMIT = 3;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_PCT   = 2'd1,
      MODE_DIGIT = 2'd2
   } mode_type;

   // Up to three decoded bytes produced by one input beat
   typedef struct packed {
      logic [1:0]                 count;
      logic [MAX_EMIT-1:0][7:0]   bytes;
      logic                       last;
   } group_type;

   typedef struct packed {
      logic      valid;
      group_type group;
   } write_type;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= CHAR_0) && (c <= CHAR_9)) ||
             ((c >= CHAR_LA) && (c <= CHAR_LF)) ||
             ((c >= CHAR_UA) && (c <= CHAR_UF));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         d = c - CHAR_0;
      end else if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
         d = c - CHAR_LA + 8'd10;
      end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
         d = c - CHAR_UA + 8'd10;
      end
      return d[3:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/upd_front.sv */
`default_nettype none
module upd_front import upd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   output write_type       wr
);

   mode_type   mode_ff, mode_in, mode_step;
   logic [7:0] held_ff, held_in;
   logic       hex_c, dec_ok;

   assign hex_c  = is_hex(in_byte);
   assign dec_ok = hex_c && is_hex(held_ff);

   // Next state: mode after this character, before the end-of-string flush
   always_comb begin
      unique case (mode_ff)
         MODE_PCT: begin
            if (hex_c) begin
               mode_step = MODE_DIGIT;
            end else begin
               mode_step = (in_byte == CHAR_PCT) ? MODE_PCT : MODE_PLAIN;
            end
         end
         MODE_DIGIT: begin
            if (dec_ok) begin
               mode_step = MODE_PLAIN;
            end else begin
               mode_step = (in_byte == CHAR_PCT) ? MODE_PCT : MODE_PLAIN;
            end
         end
         default: begin
            mode_step = (in_byte == CHAR_PCT) ? MODE_PCT : MODE_PLAIN;
         end
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      if (accept) begin
         mode_in = in_last ? MODE_PLAIN : mode_step;
         if ((mode_ff == MODE_PCT) && hex_c) begin
            held_in = in_byte;
         end
      end
   end

   // Outputs: build the group of decoded bytes for this beat
   always_comb begin
      logic [1:0]               n;
      logic [MAX_EMIT-1:0][7:0] b;
      logic                     replay;
      n      = 2'd0;
      b      = '0;
      replay = 1'b0;
      unique case (mode_ff)
         MODE_PCT: begin
            if (!hex_c) begin
               b[n]   = CHAR_PCT;
               n      = n + 2'd1;
               replay = 1'b1;
            end
         end
         MODE_DIGIT: begin
            if (dec_ok) begin
               b[n] = {hex_val(held_ff), hex_val(in_byte)};
               n    = n + 2'd1;
            end else begin
               b[n]   = CHAR_PCT;
               n      = n + 2'd1;
               b[n]   = held_ff;
               n      = n + 2'd1;
               replay = 1'b1;
            end
         end
         default: begin
            replay = 1'b1;
         end
      endcase
      // Rescan the character as plain text
      if (replay) begin
         if (in_byte == CHAR_PLUS) begin
            b[n] = CHAR_SPACE;
            n    = n + 2'd1;
         end else if (in_byte != CHAR_PCT) begin
            b[n] = in_byte;
            n    = n + 2'd1;
         end
      end
      // Flush a pending escape at end of string
      if (in_last) begin
         if (mode_step == MODE_PCT) begin
            b[n] = CHAR_PCT;
            n    = n + 2'd1;
         end else if (mode_step == MODE_DIGIT) begin
            b[n] = CHAR_PCT;
            n    = n + 2'd1;
            b[n] = in_byte;
            n    = n + 2'd1;
         end
      end
      wr.valid       = accept && (n != 2'd0);
      wr.group.count = n;
      wr.group.bytes = b;
      wr.group.last  = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         held_ff <= 8'd0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

   a_last_clears_mode: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> mode_ff == MODE_PLAIN)
      else $error("escape mode not cleared after end of string");

   a_held_is_hex: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DIGIT |-> is_hex(held_ff))
      else $error("held digit is not a hex character");

   a_plain_emits: assert property (@(posedge clock) disable iff (reset)
      accept && (mode_ff == MODE_PLAIN) && (in_byte != CHAR_PCT) |-> wr.valid)
      else $error("plain character produced no output");

endmodule
`default_nettype wire

/* rtl/core/upd_queue.sv */
`default_nettype none
module upd_queue import upd_pkg::*; #(
   parameter int unsigned DEPTH = QDEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  write_type wr,
   input  wire logic rd_en,
   output group_type head,
   output logic      nonempty,
   output logic      full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign head     = entries_ff[rptr_ff];
   assign nonempty = (count_ff != '0);
   assign full     = (count_ff == CNT_FULL);

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr.valid) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (rd_en) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (wr.valid && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr.valid && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         entries_ff[wptr_ff] <= wr.group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr.valid |-> !full)
      else $error("group written into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> nonempty)
      else $error("group read from an empty queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wptr_ff == rptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

/* rtl/core/upd_back.sv */
`default_nettype none
module upd_back import upd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  group_type       head,
   input  wire logic       nonempty,
   output logic            rd_en,
   input  wire logic       pop,
   output logic            empty,
   output logic [7:0]      out_byte,
   output logic            out_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] sub_ff, sub_in;
   logic       load, final_sub;

   assign empty    = !valid_ff;
   assign out_byte = byte_ff;
   assign out_last = last_ff;

   // Refill the output register whenever it is free or being drained
   assign load      = nonempty && (!valid_ff || pop);
   assign final_sub = (sub_ff == head.count - 2'd1);
   assign rd_en     = load && final_sub;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      sub_in   = sub_ff;
      if (valid_ff && pop) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head.bytes[sub_ff];
         last_in  = head.last && final_sub;
         sub_in   = final_sub ? 2'd0 : sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

/* rtl/core/url_percent_decoder.sv */
// A decoded byte is written into the group queue at the edge that accepts its input beat,
// then loaded into the result register that drives the result ports.
// Throughput: one input beat per cycle while each beat yields at most one byte and pop is
// held high; a beat that yields more bytes sends them one by one through the single result
// register, and full rises once the group queue (QUEUE_DEPTH groups) is taken.
// Reset: synchronous, active high; clears escape state, empties the queue and marks the result register empty.
`default_nettype none
module url_percent_decoder import upd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QDEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_byte,
   input  wire logic       req_last,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_byte,
   output logic            rsp_last
);

   write_type wr;
   group_type head;
   logic      accept, nonempty, rd_en;

   assign accept = push && !full;

   upd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_byte),
      .in_last (req_last),
      .wr      (wr)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_en    (rd_en),
      .head     (head),
      .nonempty (nonempty),
      .full     (full)
   );

   upd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .nonempty (nonempty),
      .rd_en    (rd_en),
      .pop      (pop),
      .empty    (empty),
      .out_byte (rsp_byte),
      .out_last (rsp_last)
   );

endmodule
`default_nettype wire

/* dv/url_percent_decoder_tb.sv */
module url_percent_decoder_tb;
   import upd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } decoded_beat_type;

   class decode_board;
      mode_type         mode;
      logic [7:0]       held;
      logic [7:0]       step_out[$];
      decoded_beat_type decoded_q[$];
      int               mismatches;

      function new();
         mode       = MODE_PLAIN;
         held       = 8'd0;
         mismatches = 0;
      endfunction

      function int digit_value(logic [7:0] c);
         if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
         if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
         if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
         return -1;
      endfunction

      function void plain_char(logic [7:0] c);
         if (c == CHAR_PLUS) begin
            step_out.push_back(CHAR_SPACE);
         end else if (c == CHAR_PCT) begin
            mode = MODE_PCT;
         end else begin
            step_out.push_back(c);
         end
      endfunction

      // Predict the bytes that one accepted character yields
      function void note_char(logic [7:0] c, logic fin);
         int               lo;
         int               hi;
         logic [7:0]       value;
         decoded_beat_type beat;
         step_out.delete();
         lo = digit_value(c);
         case (mode)
            MODE_PCT: begin
               if (lo >= 0) begin
                  held = c;
                  mode = MODE_DIGIT;
               end else begin
                  step_out.push_back(CHAR_PCT);
                  mode = MODE_PLAIN;
                  plain_char(c);
               end
            end
            MODE_DIGIT: begin
               hi = digit_value(held);
               if (lo >= 0 && hi >= 0) begin
                  value = 8'((hi << 4) | lo);
                  step_out.push_back(value);
                  mode = MODE_PLAIN;
               end else begin
                  step_out.push_back(CHAR_PCT);
                  step_out.push_back(held);
                  mode = MODE_PLAIN;
                  plain_char(c);
               end
            end
            default: begin
               mode = MODE_PLAIN;
               plain_char(c);
            end
         endcase
         if (fin) begin
            // flush an unfinished escape as literal text
            if (mode == MODE_PCT) begin
               step_out.push_back(CHAR_PCT);
            end else if (mode == MODE_DIGIT) begin
               step_out.push_back(CHAR_PCT);
               step_out.push_back(held);
            end
            mode = MODE_PLAIN;
         end
         foreach (step_out[i]) begin
            beat.data = step_out[i];
            beat.last = fin && (i == step_out.size() - 1);
            decoded_q.push_back(beat);
         end
      endfunction

      function void check_byte(logic [7:0] data, logic last);
         decoded_beat_type want;
         if (decoded_q.size() == 0) begin
            $error("unexpected beat: rsp_byte %h rsp_last %b", data, last);
            mismatches++;
            return;
         end
         want = decoded_q.pop_front();
         if (data !== want.data) begin
            $error("rsp_byte expected %h actual %h", want.data, data);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("rsp_last expected %b actual %b", want.last, last);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return decoded_q.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_byte;
   logic       req_last;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_byte;
   logic       rsp_last;

   decode_board board;
   logic        no_gaps;
   int unsigned cycles;
   int          chars_sent;

   url_percent_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_byte (req_byte),
      .req_last (req_last),
      .empty    (empty),
      .pop      (pop),
      .rsp_byte (rsp_byte),
      .rsp_last (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: check accepted beats, stall pop at random
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            board.check_byte(rsp_byte, rsp_last);
         end
         pop <= no_gaps || ($urandom_range(99) >= 15);
      end
   end

   task automatic send_char(input logic [7:0] c, input logic fin);
      while (!no_gaps && $urandom_range(99) < 15) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_byte <= c;
      req_last <= fin;
      do begin
         @(posedge clock);
      end while (full);
      board.note_char(c, fin);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] random_hex_digit();
      int unsigned r;
      r = $urandom_range(21);
      if (r < 10) return 8'(CHAR_0 + r);
      if (r < 16) return 8'(CHAR_LA + (r - 10));
      return 8'(CHAR_UA + (r - 16));
   endfunction

   // Well-formed escapes with random digits in half the pieces, plus noise and broken escapes
   task automatic send_random_string();
      logic [7:0]  text[$];
      int unsigned pieces;
      pieces = $urandom_range(1, 8);
      repeat (pieces) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               text.push_back(CHAR_PCT);
               text.push_back(random_hex_digit());
               text.push_back(random_hex_digit());
            end
            5: text.push_back(CHAR_PLUS);
            6: text.push_back(CHAR_PCT);
            7: begin
               text.push_back(CHAR_PCT);
               text.push_back(random_hex_digit());
            end
            default: text.push_back(8'($urandom_range(1, 255)));
         endcase
      end
      foreach (text[i]) begin
         send_char(text[i], i == text.size() - 1);
      end
   endtask

   initial begin
      board      = new();
      cycles     = 0;
      chars_sent = 0;
      no_gaps    = 1'b0;
      reset      = 1'b1;
      push       = 1'b0;
      pop        = 1'b0;
      req_byte   = 8'd0;
      req_last   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_text("+%41");
      send_text("%6f%00");
      send_text("%g%4z");
      send_text("%%41");
      send_text("%4+");
      send_text("%");
      send_text("%F");
      send_text("\001\377");

      while (chars_sent < 160) begin
         // hold both sides busy through the middle of the random part
         no_gaps = (chars_sent >= 60 && chars_sent < 110);
         send_random_string();
      end
      no_gaps = 1'b0;
      push <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
